[sv/dual_glcd_command_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dual graphic panel command sequencer
// Shared shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef DUAL_GLCD_COMMAND_SEQUENCER_MACROS_SVH
`define DUAL_GLCD_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define DGCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define DGCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dgcs_pkg.sv]
// ----------------------------------------------------------------------------
// dgcs_pkg
// Types, panel geometry and command bytes for the panel command sequencer.
// ----------------------------------------------------------------------------
package dgcs_pkg;

    // panel geometry; each count is a power of two, so a position modulo a
    // count is its low bits
    localparam int unsigned PANEL_COLUMNS = 128;
    localparam int unsigned BYTE_ROWS     = 8;
    localparam int unsigned HALF_COLUMNS  = PANEL_COLUMNS / 2;
    localparam int unsigned SCAN_LINES    = 8 * BYTE_ROWS;

    localparam int unsigned COL_W  = (PANEL_COLUMNS > 2) ? $clog2(PANEL_COLUMNS) : 1;
    localparam int unsigned ROW_W  = (BYTE_ROWS > 2) ? $clog2(BYTE_ROWS) : 1;
    localparam int unsigned LINE_W = $clog2(SCAN_LINES);

    localparam logic [7:0] CMD_OFF = 8'h3e;
    localparam logic [7:0] CMD_ON  = 8'h3f;
    localparam logic [7:0] CMD_COL = 8'h40;
    localparam logic [7:0] CMD_ROW = 8'hb8;
    localparam logic [7:0] CMD_TOP = 8'hc0;

    typedef enum logic [2:0] {
        ACT_SET_POS   = 3'd0,
        ACT_SCROLL    = 3'd1,
        ACT_WRITE     = 3'd2,
        ACT_DISPLAY   = 3'd3,
        ACT_BACKLIGHT = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_POLL  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef logic [2:0] step_t;

    // steps of the set position, scroll and display runs
    localparam step_t ST_POLL_L   = 3'd0;
    localparam step_t ST_POLL_R   = 3'd1;
    localparam step_t ST_CMD_BOTH = 3'd2;
    localparam step_t ST_POLL_COL = 3'd3;
    localparam step_t ST_CMD_COL  = 3'd4;

    // steps of the data write run
    localparam step_t ST_WR_POLL     = 3'd0;
    localparam step_t ST_WR_DATA     = 3'd1;
    localparam step_t ST_WR_POLL_COL = 3'd2;
    localparam step_t ST_WR_CMD_COL  = 3'd3;

    typedef struct packed {
        action_t             action;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    column;
        logic [LINE_W-1:0]   line;
        logic [7:0]          data;
        logic                on;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic        sel_left;
        logic        sel_right;
        logic        dni;
        logic [7:0]  bus_byte;
        logic        backlight;
        logic        last;
    } beat_t;

    typedef struct packed {
        logic               col_we;
        logic [COL_W-1:0]   col_value;
        logic               bl_we;
        logic               bl_value;
    } state_upd_t;

endpackage

[sv/dual_glcd_command_sequencer.sv]
// ----------------------------------------------------------------------------
// dual_glcd_command_sequencer
// Turns host commands for a two-controller 128x64 graphic panel into runs
// of controller bus beats (busy polls, command writes, data writes).
// ----------------------------------------------------------------------------
// Each accepted command is held in a command register and expands into a
// run of one to five result beats, one beat per clock into the output
// register while the output is not stalled: set position gives five
// beats, scroll and display on/off give three, a data write gives two
// (four when the column crosses into the other half or wraps to zero,
// which re-addresses the new half), and a backlight change gives a single
// beat with no bus cycle. The output register issuing one beat per cycle
// sets the rate, and the next command is taken in the same cycle that the
// last beat of the current one enters the output register, so the output
// register stays loaded across a continuous stream of commands. Action
// codes five to seven are accepted and dropped without any beat or state
// change. The block tracks the write column and the backlight level; both reset to zero.
// ----------------------------------------------------------------------------
module dual_glcd_command_sequencer
    import dgcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // row[7:0], column_in[15:8], top_line[23:16],
                                    // data_byte[31:24], on_flag[32], zero[39:33]
    input  logic [2:0]   s_tuser,   // action[2:0]

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // select_left[0], select_right[1], bus_byte[9:2],
                                    // backlight[10], zero[15:11]
    output logic [2:0]   m_tuser,   // cycle_kind[1:0], data_not_instruction[2]
    output logic         m_tlast
);

    // command holding stage
    logic              busy_reg,  busy_next;
    cmd_t              cmd_reg,   cmd_next;
    step_t             step_reg,  step_next;

    // architectural state
    logic [COL_W-1:0]  column_reg,    column_next;
    logic              backlight_reg, backlight_next;

    // output stage
    logic              m_valid_reg, m_valid_next;
    beat_t             out_reg,     out_next;

    beat_t             beat;
    state_upd_t        upd;
    logic              load_beat;
    logic              accept;
    logic              action_known;

    dgcs_step u_step (
        .cmd          (cmd_reg),
        .step         (step_reg),
        .column       (column_reg),
        .backlight_in (backlight_reg),
        .beat         (beat),
        .upd          (upd)
    );

    // Advance the run whenever the output slot is free or being drained.
    assign load_beat    = busy_reg && (!m_valid_reg || m_tready);
    // Take a new command when idle or as the last beat of this run leaves.
    assign s_tready     = !busy_reg || (load_beat && beat.last);
    assign accept       = s_tvalid && s_tready;
    assign action_known = (s_tuser <= 3'(ACT_BACKLIGHT));

    // Capture the command; keep the low bits of each position, which is the
    // position modulo its power-of-two range.
    always_comb begin
        cmd_next.action = action_t'(s_tuser);
        cmd_next.row    = s_tdata[0 +: ROW_W];
        cmd_next.column = s_tdata[8 +: COL_W];
        cmd_next.line   = s_tdata[16 +: LINE_W];
        cmd_next.data   = s_tdata[31:24];
        cmd_next.on     = s_tdata[32];
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        priority if (accept) begin
            // drop unknown actions: no run starts
            busy_next = action_known;
            step_next = '0;
        end else if (load_beat) begin
            busy_next = !beat.last;
            step_next = step_reg + 1'b1;
        end
    end

    always_comb begin
        column_next    = column_reg;
        backlight_next = backlight_reg;
        if (load_beat && upd.col_we) begin
            column_next = upd.col_value;
        end
        if (load_beat && upd.bl_we) begin
            backlight_next = upd.bl_value;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        priority if (load_beat) begin
            m_valid_next = 1'b1;
            out_next     = beat;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            column_reg    <= '0;
            backlight_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            column_reg    <= column_next;
            backlight_reg <= backlight_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_reg.backlight, out_reg.bus_byte,
                       out_reg.sel_right, out_reg.sel_left};
    assign m_tuser  = {out_reg.dni, out_reg.kind};
    assign m_tlast  = out_reg.last;

endmodule

[sv/dgcs_step.sv]
// ----------------------------------------------------------------------------
// dgcs_step
// Beat generator: builds one controller bus beat from the held command,
// its step index and the current column and backlight level.
// ----------------------------------------------------------------------------
module dgcs_step
    import dgcs_pkg::*;
(
    input  cmd_t              cmd,
    input  step_t             step,
    input  logic [COL_W-1:0]  column,
    input  logic              backlight_in,
    output beat_t             beat,
    output state_upd_t        upd
);

    logic [COL_W-1:0] cmd_col_half;
    logic             cmd_col_left;
    logic [COL_W-1:0] cur_col_half;
    logic             cur_col_left;
    logic [COL_W-1:0] next_col;
    logic             next_wraps;
    logic [7:0]       both_byte;

    always_comb begin
        cmd_col_left = cmd.column < COL_W'(HALF_COLUMNS);
        cmd_col_half = cmd_col_left ? cmd.column : cmd.column - COL_W'(HALF_COLUMNS);
        cur_col_left = column < COL_W'(HALF_COLUMNS);
        cur_col_half = cur_col_left ? column : column - COL_W'(HALF_COLUMNS);
        next_col     = (column == COL_W'(PANEL_COLUMNS - 1)) ? '0 : column + 1'b1;
        next_wraps   = (next_col == '0) || (next_col == COL_W'(HALF_COLUMNS));
    end

    always_comb begin
        unique case (cmd.action)
            ACT_SET_POS: both_byte = CMD_ROW | 8'(cmd.row);
            ACT_SCROLL:  both_byte = CMD_TOP | 8'(cmd.line);
            default:     both_byte = cmd.on ? CMD_ON : CMD_OFF;
        endcase
    end

    always_comb begin
        beat.kind      = KIND_POLL;
        beat.sel_left  = 1'b0;
        beat.sel_right = 1'b0;
        beat.dni       = 1'b0;
        beat.bus_byte  = '0;
        beat.backlight = backlight_in;
        beat.last      = 1'b0;
        upd.col_we     = 1'b0;
        upd.col_value  = cmd.column;
        upd.bl_we      = 1'b0;
        upd.bl_value   = cmd.on;

        unique case (cmd.action)
            ACT_WRITE: begin
                unique case (step)
                    ST_WR_POLL: begin
                        beat.sel_left  = cur_col_left;
                        beat.sel_right = !cur_col_left;
                    end
                    ST_WR_DATA: begin
                        beat.kind      = KIND_WRITE;
                        beat.sel_left  = cur_col_left;
                        beat.sel_right = !cur_col_left;
                        beat.dni       = 1'b1;
                        beat.bus_byte  = cmd.data;
                        beat.last      = !next_wraps;
                        upd.col_we     = 1'b1;
                        upd.col_value  = next_col;
                    end
                    // column already advanced: re-address the new half
                    ST_WR_POLL_COL: begin
                        beat.sel_left  = cur_col_left;
                        beat.sel_right = !cur_col_left;
                    end
                    default: begin
                        beat.kind      = KIND_WRITE;
                        beat.sel_left  = cur_col_left;
                        beat.sel_right = !cur_col_left;
                        beat.bus_byte  = CMD_COL | 8'(cur_col_half);
                        beat.last      = 1'b1;
                    end
                endcase
            end
            ACT_BACKLIGHT: begin
                beat.kind      = KIND_NONE;
                beat.backlight = cmd.on;
                beat.last      = 1'b1;
                upd.bl_we      = 1'b1;
            end
            default: begin
                unique case (step)
                    ST_POLL_L: begin
                        beat.sel_left = 1'b1;
                    end
                    ST_POLL_R: begin
                        beat.sel_right = 1'b1;
                    end
                    ST_CMD_BOTH: begin
                        beat.kind      = KIND_WRITE;
                        beat.sel_left  = 1'b1;
                        beat.sel_right = 1'b1;
                        beat.bus_byte  = both_byte;
                        beat.last      = (cmd.action != ACT_SET_POS);
                    end
                    ST_POLL_COL: begin
                        beat.sel_left  = cmd_col_left;
                        beat.sel_right = !cmd_col_left;
                    end
                    default: begin
                        beat.kind      = KIND_WRITE;
                        beat.sel_left  = cmd_col_left;
                        beat.sel_right = !cmd_col_left;
                        beat.bus_byte  = CMD_COL | 8'(cmd_col_half);
                        beat.last      = 1'b1;
                        upd.col_we     = 1'b1;
                    end
                endcase
            end
        endcase
    end

endmodule

[sv/dgcs_checker.sv]
// ----------------------------------------------------------------------------
// dgcs_checker
// Port-level checks on the beats leaving the panel command sequencer.
// ----------------------------------------------------------------------------
`include "dual_glcd_command_sequencer_macros.svh"

module dgcs_checker
    import dgcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast
);

    // a stalled beat holds
    `DGCS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled beat changed")

    // a busy poll reads one chip's status and never ends a run
    `DGCS_ASSERT_SAME(a_poll_shape, aclk, aresetn, m_tvalid && m_tuser[1:0] == KIND_POLL, $onehot(m_tdata[1:0]) && m_tdata[9:2] == 8'd0 && !m_tuser[2] && !m_tlast, "malformed poll beat")

    // a backlight beat selects nothing, drives no byte and ends its run
    `DGCS_ASSERT_SAME(a_none_shape, aclk, aresetn, m_tvalid && m_tuser[1:0] == KIND_NONE, m_tdata[1:0] == 2'b00 && m_tdata[9:2] == 8'd0 && !m_tuser[2] && m_tlast, "malformed no-bus beat")

    // pixel data goes to exactly one half
    `DGCS_ASSERT_SAME(a_data_one_chip, aclk, aresetn, m_tvalid && m_tuser[2], m_tuser[1:0] == KIND_WRITE && $onehot(m_tdata[1:0]), "data beat not a single-chip write")

endmodule

bind dual_glcd_command_sequencer dgcs_checker u_dgcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
